>>> rtl/bffl_pkg.sv
package bffl_pkg;

    // region geometry
    localparam int REGION_BYTES = 65536;
    localparam int BANKS        = 4;
    localparam int WORDS        = REGION_BYTES / BANKS;
    localparam int IDX_W        = $clog2(WORDS);
    localparam int OFF_W        = $clog2(REGION_BYTES);
    localparam int END_W        = OFF_W + 1;

    // list layout
    localparam logic [31:0] FIRST_NODE_OFFSET = 32'd8;
    localparam logic [31:0] LEN_HDR           = 32'd4;
    localparam logic [31:0] NODE_BYTES        = 32'd8;
    localparam logic [31:0] MIN_REGION        = 32'd16;
    localparam int          MAX_WALK          = REGION_BYTES / 8 + 1;
    localparam int          STEP_W            = $clog2(MAX_WALK + 1);
    // write that lands outside the store and is dropped
    localparam logic [31:0] DUMMY_ADDR        = 32'hFFFF_FFFF;
    localparam int          SLOTS             = 4;

    // commands
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_GROW   = 2'd2;
    localparam logic [1:0] CMD_SHRINK = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_NOT_PLACED = 2'd2;
    localparam logic [1:0] ST_SHRINK_HIT = 2'd3;

    typedef enum logic [20:0] {
        S_CLEAR   = 21'h000001,
        S_FORMAT  = 21'h000002,
        S_IDLE    = 21'h000004,
        S_A_SZ    = 21'h000008,
        S_A_NX    = 21'h000010,
        S_A_EV    = 21'h000020,
        S_A_END   = 21'h000040,
        S_F_LEN   = 21'h000080,
        S_F_LENQ  = 21'h000100,
        S_P_START = 21'h000200,
        S_P_SZ    = 21'h000400,
        S_P_NX    = 21'h000800,
        S_P_EV    = 21'h001000,
        S_P_M_SZ  = 21'h002000,
        S_P_M_NX  = 21'h004000,
        S_P_M_EV  = 21'h008000,
        S_S_CHK   = 21'h010000,
        S_S_SZ    = 21'h020000,
        S_S_NX    = 21'h040000,
        S_WRITE   = 21'h080000,
        S_DONE    = 21'h100000
    } state_t;

    // saturate a region size to [MIN_REGION, REGION_BYTES]
    function automatic logic [END_W-1:0] clamp_region(input logic [END_W-1:0] v);
        logic [END_W-1:0] r;
        r = v;
        if (32'(v) < MIN_REGION)
            r = END_W'(MIN_REGION);
        else if (32'(v) > 32'(REGION_BYTES))
            r = END_W'(REGION_BYTES);
        return r;
    endfunction

endpackage

>>> rtl/best_fit_free_list_allocator.sv
// Allocate walks the whole free list through S_A_SZ, S_A_NX and S_A_EV for each node,
//   closes the walk in S_A_END, drains up to 4 queued store writes and registers the result.
//   Free, grow and shrink stop at the node where they act (S_P_SZ, S_P_NX and S_P_EV, or
//   S_S_CHK, S_S_SZ and S_S_NX for each node; a three-way merge adds S_P_M_SZ to S_P_M_EV).
// Throughput: one item at a time; set by list length through the single store port.
// Reset and every configuration write: a clearing pass over the store in S_CLEAR,
//   then S_FORMAT writes the initial free node; no item is accepted meanwhile.
module best_fit_free_list_allocator
    import bffl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // command [1:0], request_bytes [17:2], block_offset [33:18],
    // new_region_bytes [50:34], zero fill
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // granted_offset [15:0], status [17:16], zero fill
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data
);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [END_W-1:0]  init_reg, init_next;
    logic [31:0]       head_reg, head_next;
    logic [END_W-1:0]  region_end_reg, region_end_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // walk state
    logic [31:0]       need_reg, need_next;
    logic [31:0]       off_reg, off_next;
    logic [31:0]       len_reg, len_next;
    logic [END_W-1:0]  tgt_reg, tgt_next;
    logic [31:0]       cur_reg, cur_next;
    logic [31:0]       prev_reg, prev_next;
    logic [31:0]       psz_reg, psz_next;
    logic              has_prev_reg, has_prev_next;
    logic [31:0]       sz_reg, sz_next;
    logic [31:0]       nx_reg, nx_next;
    logic [31:0]       aux_reg, aux_next;
    logic [STEP_W-1:0] steps_reg, steps_next;

    // best fit so far
    logic              found_reg, found_next;
    logic              b_has_reg, b_has_next;
    logic [31:0]       b_off_reg, b_off_next;
    logic [31:0]       b_prev_reg, b_prev_next;
    logic [31:0]       b_size_reg, b_size_next;
    logic [31:0]       b_next_reg, b_next_next;

    // queued store writes, drained in order
    logic [31:0]       slot_addr_reg [SLOTS];
    logic [31:0]       slot_addr_next [SLOTS];
    logic [31:0]       slot_data_reg [SLOTS];
    logic [31:0]       slot_data_next [SLOTS];
    logic [2:0]        slot_cnt_reg, slot_cnt_next;
    logic [1:0]        wr_idx_reg, wr_idx_next;

    // pending result
    logic [1:0]        status_reg, status_next;
    logic [15:0]       granted_reg, granted_next;
    logic [23:0]       m_tdata_reg, m_tdata_next;

    // store port
    logic              wr_en;
    logic [31:0]       wr_addr;
    logic [31:0]       wr_data;
    logic [31:0]       rd_addr;
    logic [31:0]       rdata;

    logic              b_we    [BANKS];
    logic [IDX_W-1:0]  b_widx  [BANKS];
    logic [7:0]        b_wbyte [BANKS];
    logic [IDX_W-1:0]  b_ridx  [BANKS];
    logic              b_rok   [BANKS];
    logic [1:0]        b_rk    [BANKS];
    logic [7:0]        rq      [BANKS];
    logic              rok_reg [BANKS];
    logic [1:0]        rk_reg  [BANKS];

    // input fields
    logic [1:0]        in_cmd;
    logic [15:0]       in_req;
    logic [15:0]       in_blk;
    logic [END_W-1:0]  in_nrb;
    logic [31:0]       need_calc;
    logic [END_W-1:0]  tgt_calc;
    logic [31:0]       end_w;
    logic [31:0]       split_at;
    logic [31:0]       remain;
    logic              touch_prev;
    logic              touch_next;

    assign in_cmd = s_tdata[1:0];
    assign in_req = s_tdata[17:2];
    assign in_blk = s_tdata[33:18];
    assign in_nrb = s_tdata[50:34];

    assign need_calc  = (32'(in_req) + LEN_HDR < NODE_BYTES) ? NODE_BYTES
                                                              : 32'(in_req) + LEN_HDR;
    assign tgt_calc   = clamp_region(in_nrb);
    assign end_w      = cur_reg + sz_reg;
    assign split_at   = b_off_reg + need_reg;
    assign remain     = b_size_reg - need_reg;
    assign touch_prev = has_prev_reg && (prev_reg + psz_reg == off_reg);
    assign touch_next = (off_reg + len_reg == cur_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // byte lanes: each bank holds one byte position of a word
    always_comb
    begin
        logic [1:0]  k;
        logic [16:0] sum;
        for (int j = 0; j < BANKS; j++)
        begin
            // write side
            k   = 2'(j) - wr_addr[1:0];
            sum = {1'b0, wr_addr[15:0]} + 17'(k);
            if (state_reg == S_CLEAR)
            begin
                b_we[j]    = 1'b1;
                b_widx[j]  = clr_cnt_reg;
                b_wbyte[j] = 8'd0;
            end
            else
            begin
                b_we[j]    = wr_en && (wr_addr[31:16] == 16'd0) && !sum[16];
                b_widx[j]  = sum[15:2];
                b_wbyte[j] = wr_data[{k, 3'b000} +: 8];
            end
            // read side
            k         = 2'(j) - rd_addr[1:0];
            sum       = {1'b0, rd_addr[15:0]} + 17'(k);
            b_ridx[j] = sum[15:2];
            b_rok[j]  = (rd_addr[31:16] == 16'd0) && !sum[16];
            b_rk[j]   = k;
        end
    end

    for (genvar j = 0; j < BANKS; j++)
    begin : g_bank
        logic [7:0] mem [WORDS];
        logic [7:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (b_we[j])
                mem[b_widx[j]] <= b_wbyte[j];
            q_reg <= mem[b_ridx[j]];
        end

        assign rq[j] = q_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < BANKS; j++)
        begin
            rok_reg[j] <= b_rok[j];
            rk_reg[j]  <= b_rk[j];
        end
    end

    // reassemble the word; bytes beyond the store read as zero
    always_comb
    begin
        rdata = '0;
        for (int j = 0; j < BANKS; j++)
            rdata[{rk_reg[j], 3'b000} +: 8] = rok_reg[j] ? rq[j] : 8'd0;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        init_next       = init_reg;
        head_next       = head_reg;
        region_end_next = region_end_reg;
        m_tvalid_next   = m_tvalid_reg;
        need_next       = need_reg;
        off_next        = off_reg;
        len_next        = len_reg;
        tgt_next        = tgt_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        psz_next        = psz_reg;
        has_prev_next   = has_prev_reg;
        sz_next         = sz_reg;
        nx_next         = nx_reg;
        aux_next        = aux_reg;
        steps_next      = steps_reg;
        found_next      = found_reg;
        b_has_next      = b_has_reg;
        b_off_next      = b_off_reg;
        b_prev_next     = b_prev_reg;
        b_size_next     = b_size_reg;
        b_next_next     = b_next_reg;
        slot_addr_next  = slot_addr_reg;
        slot_data_next  = slot_data_reg;
        slot_cnt_next   = slot_cnt_reg;
        wr_idx_next     = wr_idx_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        m_tdata_next    = m_tdata_reg;

        wr_en   = 1'b0;
        wr_addr = slot_addr_reg[wr_idx_reg];
        wr_data = slot_data_reg[wr_idx_reg];
        rd_addr = cur_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(WORDS - 1))
                    state_next = S_FORMAT;
            end

            S_FORMAT:
            begin
                wr_en           = 1'b1;
                wr_addr         = FIRST_NODE_OFFSET;
                wr_data         = 32'(clamp_region(init_reg)) - FIRST_NODE_OFFSET;
                head_next       = FIRST_NODE_OFFSET;
                region_end_next = clamp_region(init_reg);
                state_next      = S_IDLE;
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    granted_next  = 16'd0;
                    status_next   = ST_OK;
                    cur_next      = head_reg;
                    prev_next     = 32'd0;
                    has_prev_next = 1'b0;
                    steps_next    = '0;
                    found_next    = 1'b0;
                    unique case (in_cmd)
                        CMD_ALLOC:
                        begin
                            need_next  = need_calc;
                            state_next = S_A_SZ;
                        end
                        CMD_FREE:
                        begin
                            if (in_blk < 16'(FIRST_NODE_OFFSET + LEN_HDR)
                                || END_W'(in_blk) >= region_end_reg)
                            begin
                                status_next = ST_NOT_PLACED;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                off_next   = 32'(in_blk) - LEN_HDR;
                                state_next = S_F_LEN;
                            end
                        end
                        CMD_GROW:
                        begin
                            if (region_end_reg >= tgt_calc)
                                state_next = S_DONE;
                            else
                            begin
                                region_end_next = tgt_calc;
                                off_next        = 32'(region_end_reg);
                                len_next        = 32'(tgt_calc) - 32'(region_end_reg);
                                state_next      = S_P_START;
                            end
                        end
                        CMD_SHRINK:
                        begin
                            tgt_next = tgt_calc;
                            if (region_end_reg <= tgt_calc)
                                state_next = S_DONE;
                            else
                                state_next = S_S_CHK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // allocate: visit every node, keep the smallest fit
            S_A_SZ:
            begin
                rd_addr = cur_reg;
                if (cur_reg == 32'd0 || steps_reg == STEP_W'(MAX_WALK))
                    state_next = S_A_END;
                else
                    state_next = S_A_NX;
            end

            S_A_NX:
            begin
                sz_next    = rdata;
                rd_addr    = cur_reg + 32'd4;
                state_next = S_A_EV;
            end

            S_A_EV:
            begin
                if (sz_reg >= need_reg && (!found_reg || sz_reg < b_size_reg))
                begin
                    found_next  = 1'b1;
                    b_off_next  = cur_reg;
                    b_prev_next = prev_reg;
                    b_has_next  = has_prev_reg;
                    b_size_next = sz_reg;
                    b_next_next = rdata;
                end
                prev_next     = cur_reg;
                has_prev_next = 1'b1;
                cur_next      = rdata;
                steps_next    = steps_reg + 1'b1;
                state_next    = S_A_SZ;
            end

            S_A_END:
            begin
                wr_idx_next = 2'd0;
                if (!found_reg)
                begin
                    status_next = ST_NO_FIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    granted_next = 16'(b_off_reg + LEN_HDR);
                    state_next   = S_WRITE;
                    if (remain >= NODE_BYTES)
                    begin
                        // split: new node after the block, relink, block header
                        slot_addr_next[0] = split_at;
                        slot_data_next[0] = remain;
                        slot_addr_next[1] = split_at + 32'd4;
                        slot_data_next[1] = b_next_reg;
                        slot_addr_next[2] = b_has_reg ? b_prev_reg + 32'd4 : DUMMY_ADDR;
                        slot_data_next[2] = split_at;
                        if (!b_has_reg)
                            head_next = split_at;
                        slot_addr_next[3] = b_off_reg;
                        slot_data_next[3] = need_reg;
                        slot_cnt_next     = 3'd4;
                    end
                    else
                    begin
                        // whole node taken
                        slot_addr_next[0] = b_has_reg ? b_prev_reg + 32'd4 : DUMMY_ADDR;
                        slot_data_next[0] = b_next_reg;
                        if (!b_has_reg)
                            head_next = b_next_reg;
                        slot_addr_next[1] = b_off_reg;
                        slot_data_next[1] = b_size_reg;
                        slot_cnt_next     = 3'd2;
                    end
                end
            end

            // free: fetch the block length
            S_F_LEN:
            begin
                rd_addr    = off_reg;
                state_next = S_F_LENQ;
            end

            S_F_LENQ:
            begin
                len_next   = rdata;
                state_next = S_P_START;
            end

            // place a free block in address order
            S_P_START:
            begin
                cur_next      = head_reg;
                prev_next     = 32'd0;
                has_prev_next = 1'b0;
                steps_next    = '0;
                wr_idx_next   = 2'd0;
                if (head_reg == 32'd0)
                begin
                    head_next         = off_reg;
                    slot_addr_next[0] = off_reg;
                    slot_data_next[0] = len_reg;
                    slot_addr_next[1] = off_reg + 32'd4;
                    slot_data_next[1] = 32'd0;
                    slot_cnt_next     = 3'd2;
                    state_next        = S_WRITE;
                end
                else
                    state_next = S_P_SZ;
            end

            S_P_SZ:
            begin
                rd_addr = cur_reg;
                if (cur_reg == 32'd0 || steps_reg == STEP_W'(MAX_WALK))
                begin
                    status_next = ST_NOT_PLACED;
                    state_next  = S_DONE;
                end
                else
                    state_next = S_P_NX;
            end

            S_P_NX:
            begin
                sz_next    = rdata;
                rd_addr    = cur_reg + 32'd4;
                state_next = S_P_EV;
            end

            S_P_EV:
            begin
                nx_next     = rdata;
                wr_idx_next = 2'd0;
                if (end_w == off_reg)
                begin
                    if (rdata != 32'd0 && rdata == end_w + len_reg)
                        state_next = S_P_M_SZ;
                    else
                    begin
                        slot_addr_next[0] = cur_reg;
                        slot_data_next[0] = sz_reg + len_reg;
                        slot_cnt_next     = 3'd1;
                        state_next        = S_WRITE;
                    end
                end
                else if (cur_reg > off_reg)
                begin
                    state_next = S_WRITE;
                    if (touch_prev && touch_next)
                    begin
                        slot_addr_next[0] = prev_reg;
                        slot_data_next[0] = psz_reg + len_reg + sz_reg;
                        slot_addr_next[1] = prev_reg + 32'd4;
                        slot_data_next[1] = rdata;
                        slot_cnt_next     = 3'd2;
                    end
                    else if (touch_prev)
                    begin
                        slot_addr_next[0] = prev_reg;
                        slot_data_next[0] = psz_reg + len_reg;
                        slot_cnt_next     = 3'd1;
                    end
                    else
                    begin
                        slot_addr_next[0] = off_reg;
                        slot_data_next[0] = touch_next ? len_reg + sz_reg : len_reg;
                        slot_addr_next[1] = off_reg + 32'd4;
                        slot_data_next[1] = touch_next ? rdata : cur_reg;
                        slot_addr_next[2] = has_prev_reg ? prev_reg + 32'd4 : DUMMY_ADDR;
                        slot_data_next[2] = off_reg;
                        if (!has_prev_reg)
                            head_next = off_reg;
                        slot_cnt_next = 3'd3;
                    end
                end
                else if (rdata == 32'd0 && end_w < off_reg)
                begin
                    // append after the last node
                    slot_addr_next[0] = off_reg;
                    slot_data_next[0] = len_reg;
                    slot_addr_next[1] = off_reg + 32'd4;
                    slot_data_next[1] = 32'd0;
                    slot_addr_next[2] = cur_reg + 32'd4;
                    slot_data_next[2] = off_reg;
                    slot_cnt_next     = 3'd3;
                    state_next        = S_WRITE;
                end
                else
                begin
                    prev_next     = cur_reg;
                    psz_next      = sz_reg;
                    has_prev_next = 1'b1;
                    cur_next      = rdata;
                    steps_next    = steps_reg + 1'b1;
                    state_next    = S_P_SZ;
                end
            end

            // three-way merge: absorb the following node
            S_P_M_SZ:
            begin
                rd_addr    = nx_reg;
                state_next = S_P_M_NX;
            end

            S_P_M_NX:
            begin
                aux_next   = rdata;
                rd_addr    = nx_reg + 32'd4;
                state_next = S_P_M_EV;
            end

            S_P_M_EV:
            begin
                slot_addr_next[0] = cur_reg;
                slot_data_next[0] = sz_reg + len_reg + aux_reg;
                slot_addr_next[1] = cur_reg + 32'd4;
                slot_data_next[1] = rdata;
                slot_cnt_next     = 3'd2;
                wr_idx_next       = 2'd0;
                state_next        = S_WRITE;
            end

            // shrink: find the node that reaches the new end
            S_S_CHK:
            begin
                rd_addr     = cur_reg;
                wr_idx_next = 2'd0;
                if (cur_reg == 32'd0 || steps_reg == STEP_W'(MAX_WALK))
                begin
                    region_end_next = tgt_reg;
                    state_next      = S_DONE;
                end
                else if (cur_reg == 32'(tgt_reg))
                begin
                    slot_addr_next[0] = has_prev_reg ? prev_reg + 32'd4 : DUMMY_ADDR;
                    slot_data_next[0] = 32'd0;
                    if (!has_prev_reg)
                        head_next = 32'd0;
                    slot_cnt_next   = 3'd1;
                    region_end_next = tgt_reg;
                    state_next      = S_WRITE;
                end
                else if (cur_reg < 32'(tgt_reg))
                    state_next = S_S_SZ;
                else
                begin
                    status_next = ST_SHRINK_HIT;
                    state_next  = S_DONE;
                end
            end

            S_S_SZ:
            begin
                rd_addr = cur_reg + 32'd4;
                if (rdata + cur_reg >= 32'(tgt_reg))
                begin
                    slot_addr_next[0] = cur_reg;
                    slot_data_next[0] = 32'(tgt_reg) - cur_reg;
                    slot_cnt_next     = 3'd1;
                    region_end_next   = tgt_reg;
                    state_next        = S_WRITE;
                end
                else
                    state_next = S_S_NX;
            end

            S_S_NX:
            begin
                prev_next     = cur_reg;
                has_prev_next = 1'b1;
                cur_next      = rdata;
                steps_next    = steps_reg + 1'b1;
                state_next    = S_S_CHK;
            end

            // drain queued writes in order
            S_WRITE:
            begin
                wr_en       = 1'b1;
                wr_idx_next = wr_idx_reg + 1'b1;
                if ({1'b0, wr_idx_reg} + 3'd1 == slot_cnt_reg)
                    state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, status_reg, granted_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration write reformats the region
        if (cfg_wr_en)
        begin
            init_next    = cfg_wr_data;
            clr_cnt_next = '0;
            state_next   = S_CLEAR;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            init_reg       <= END_W'(REGION_BYTES);
            head_reg       <= FIRST_NODE_OFFSET;
            region_end_reg <= END_W'(REGION_BYTES);
            m_tvalid_reg   <= 1'b0;
            slot_cnt_reg   <= '0;
            wr_idx_reg     <= '0;
            steps_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            init_reg       <= init_next;
            head_reg       <= head_next;
            region_end_reg <= region_end_next;
            m_tvalid_reg   <= m_tvalid_next;
            slot_cnt_reg   <= slot_cnt_next;
            wr_idx_reg     <= wr_idx_next;
            steps_reg      <= steps_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        need_reg      <= need_next;
        off_reg       <= off_next;
        len_reg       <= len_next;
        tgt_reg       <= tgt_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        psz_reg       <= psz_next;
        has_prev_reg  <= has_prev_next;
        sz_reg        <= sz_next;
        nx_reg        <= nx_next;
        aux_reg       <= aux_next;
        found_reg     <= found_next;
        b_has_reg     <= b_has_next;
        b_off_reg     <= b_off_next;
        b_prev_reg    <= b_prev_next;
        b_size_reg    <= b_size_next;
        b_next_reg    <= b_next_next;
        slot_addr_reg <= slot_addr_next;
        slot_data_reg <= slot_data_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // one item in flight: after an accept the block is busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous one still in work");

    // a granted offset only comes with status ok
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[15:0] != 16'd0) |-> m_tdata[17:16] == ST_OK)
        else $error("nonzero offset with failing status");

    // region end stays within the saturated range
    a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(region_end_reg) >= MIN_REGION && 32'(region_end_reg) <= 32'(REGION_BYTES)))
        else $error("region end out of range");

    // write queue never drained past its fill
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> ({1'b0, wr_idx_reg} < slot_cnt_reg))
        else $error("write queue overrun");

endmodule

>>> tb/best_fit_free_list_allocator_tb.sv
module best_fit_free_list_allocator_tb;
    import bffl_pkg::*;

    typedef struct packed {
        logic [15:0] offset;
        logic [1:0]  status;
    } grant_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] req;
        logic [15:0] blk;
        logic [16:0] nrb;
        bit          typed;
        grant_t      want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic [55:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_wr_en;
    logic [16:0] cfg_wr_data;

    best_fit_free_list_allocator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // shadow copy of the allocator state
    logic [7:0]  shadow_mem [0:REGION_BYTES-1];
    int unsigned shadow_head;
    int unsigned shadow_end;

    grant_t      pending_grants[$];
    int unsigned live_blocks[$];
    int          errors;
    int          sent_items;
    int          seen_results;
    int          idle_pct;
    int          stall_pct;
    int unsigned status_seen [4];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #200000000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // byte store access, out-of-range bytes read as zero and drop writes
    function automatic int unsigned mem_rd32(input int unsigned a);
        int unsigned v;
        v = 0;
        for (int unsigned i = 0; i < 4; i++)
            if (a < REGION_BYTES && i < REGION_BYTES - a)
                v |= int'(shadow_mem[a + i]) << (8 * i);
        return v;
    endfunction

    function automatic void mem_wr32(input int unsigned a, input int unsigned v);
        for (int unsigned i = 0; i < 4; i++)
            if (a < REGION_BYTES && i < REGION_BYTES - a)
                shadow_mem[a + i] = v[8*i +: 8];
    endfunction

    function automatic void node_wr(input int unsigned a, input int unsigned sz,
                                    input int unsigned nx);
        mem_wr32(a, sz);
        mem_wr32(a + 4, nx);
    endfunction

    function automatic void link_to(input bit has_prev, input int unsigned prev,
                                    input int unsigned v);
        if (has_prev)
            mem_wr32(prev + 4, v);
        else
            shadow_head = v;
    endfunction

    function automatic int unsigned sat_region(input int unsigned v);
        if (v < MIN_REGION)
            return MIN_REGION;
        if (v > REGION_BYTES)
            return REGION_BYTES;
        return v;
    endfunction

    function automatic void format_region(input logic [16:0] bytes);
        int unsigned sz;
        sz = sat_region(bytes);
        for (int i = 0; i < REGION_BYTES; i++)
            shadow_mem[i] = 8'h00;
        shadow_end  = sz;
        shadow_head = FIRST_NODE_OFFSET;
        node_wr(FIRST_NODE_OFFSET, sz - FIRST_NODE_OFFSET, 0);
    endfunction

    // insert a free block in address order, merging with neighbours
    function automatic bit insert_free(input int unsigned off, input int unsigned len);
        int unsigned cur, prev, prev_size, sz, nx, blk_end;
        bit has_prev, tp, tn;
        cur = shadow_head;
        prev = 0;
        prev_size = 0;
        has_prev = 0;
        if (cur == 0)
        begin
            shadow_head = off;
            node_wr(off, len, 0);
            return 1;
        end
        for (int unsigned steps = 0; cur != 0 && steps < MAX_WALK; steps++)
        begin
            sz = mem_rd32(cur);
            nx = mem_rd32(cur + 4);
            blk_end = cur + sz;
            if (blk_end == off)
            begin
                if (nx != 0 && nx == blk_end + len)
                    node_wr(cur, sz + len + mem_rd32(nx), mem_rd32(nx + 4));
                else
                    mem_wr32(cur, sz + len);
                return 1;
            end
            if (cur > off)
            begin
                tp = has_prev && prev + prev_size == off;
                tn = off + len == cur;
                if (tp && tn)
                    node_wr(prev, prev_size + len + sz, nx);
                else if (tp)
                    mem_wr32(prev, prev_size + len);
                else if (tn)
                begin
                    node_wr(off, len + sz, nx);
                    link_to(has_prev, prev, off);
                end
                else
                begin
                    node_wr(off, len, cur);
                    link_to(has_prev, prev, off);
                end
                return 1;
            end
            if (nx == 0 && blk_end < off)
            begin
                node_wr(off, len, 0);
                mem_wr32(cur + 4, off);
                return 1;
            end
            prev = cur;
            prev_size = sz;
            has_prev = 1;
            cur = nx;
        end
        return 0;
    endfunction

    // best fit, earliest node on a tie
    function automatic grant_t alloc_best_fit(input int unsigned payload);
        int unsigned need, cur, prev, sz, nx, b_off, b_prev, b_size, b_next;
        bit has_prev, b_has_prev, found;
        grant_t g;
        need = payload + LEN_HDR;
        cur = shadow_head;
        prev = 0;
        has_prev = 0;
        found = 0;
        b_off = 0; b_prev = 0; b_size = 0; b_next = 0; b_has_prev = 0;
        if (need < NODE_BYTES)
            need = NODE_BYTES;
        for (int unsigned steps = 0; cur != 0 && steps < MAX_WALK; steps++)
        begin
            sz = mem_rd32(cur);
            nx = mem_rd32(cur + 4);
            if (sz >= need && (!found || sz < b_size))
            begin
                found = 1;
                b_off = cur;
                b_prev = prev;
                b_has_prev = has_prev;
                b_size = sz;
                b_next = nx;
            end
            prev = cur;
            has_prev = 1;
            cur = nx;
        end
        g.offset = '0;
        if (!found)
        begin
            g.status = ST_NO_FIT;
            return g;
        end
        if (b_size - need >= NODE_BYTES)
        begin
            node_wr(b_off + need, b_size - need, b_next);
            link_to(b_has_prev, b_prev, b_off + need);
        end
        else
        begin
            need = b_size;
            link_to(b_has_prev, b_prev, b_next);
        end
        mem_wr32(b_off, need);
        g.offset = 16'(b_off + LEN_HDR);
        g.status = ST_OK;
        return g;
    endfunction

    function automatic logic [1:0] shrink_region(input int unsigned target);
        int unsigned cur, prev, sz;
        bit has_prev;
        cur = shadow_head;
        prev = 0;
        has_prev = 0;
        if (shadow_end <= target)
            return ST_OK;
        for (int unsigned steps = 0; cur != 0 && steps < MAX_WALK; steps++)
        begin
            if (cur == target)
            begin
                link_to(has_prev, prev, 0);
                break;
            end
            else if (cur < target)
            begin
                sz = mem_rd32(cur);
                if (sz + cur >= target)
                begin
                    mem_wr32(cur, target - cur);
                    break;
                end
                prev = cur;
                has_prev = 1;
                cur = mem_rd32(cur + 4);
            end
            else
                return ST_SHRINK_HIT;
        end
        shadow_end = target;
        return ST_OK;
    endfunction

    function automatic grant_t predict_grant(input logic [1:0] cmd, input logic [15:0] req,
                                             input logic [15:0] blk, input logic [16:0] nrb);
        grant_t g;
        int unsigned target, old;
        g = '0;
        target = sat_region(nrb);
        case (cmd)
            CMD_ALLOC:
                g = alloc_best_fit(req);
            CMD_FREE:
            begin
                if (blk < FIRST_NODE_OFFSET + LEN_HDR || blk >= shadow_end)
                    g.status = ST_NOT_PLACED;
                else
                    g.status = insert_free(blk - LEN_HDR, mem_rd32(blk - LEN_HDR))
                               ? ST_OK : ST_NOT_PLACED;
            end
            CMD_GROW:
            begin
                old = shadow_end;
                if (old < target)
                begin
                    shadow_end = target;
                    g.status = insert_free(old, target - old) ? ST_OK : ST_NOT_PLACED;
                end
            end
            default:
                g.status = shrink_region(target);
        endcase
        return g;
    endfunction

    // drive one item, predict on acceptance
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] req,
                             input logic [15:0] blk, input logic [16:0] nrb,
                             input bit typed, input grant_t want, output grant_t got);
        bit done;
        done = 0;
        while (!done)
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < idle_pct)
                s_tvalid <= 1'b0;
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {5'd0, nrb, blk, req, cmd};
                do
                    @(posedge clk);
                while (!s_tready);
                done = 1;
            end
        end
        got = predict_grant(cmd, req, blk, nrb);
        if (typed)
        begin
            if (got.offset != want.offset)
                report_mismatch("predicted offset", got.offset, want.offset);
            if (got.status != want.status)
                report_mismatch("predicted status", got.status, want.status);
            got = want;
        end
        pending_grants.push_back(got);
        sent_items++;
        if (cmd == CMD_ALLOC && got.status == ST_OK)
            live_blocks.push_back(got.offset);
    endtask

    // results are compared in order at the rising edge
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_results++;
            if (pending_grants.size() == 0)
                report_mismatch("results outstanding", 1, 0);
            else
            begin
                want = pending_grants.pop_front();
                status_seen[want.status]++;
                if (m_tdata[15:0] != want.offset)
                    report_mismatch("granted_offset", m_tdata[15:0], want.offset);
                if (m_tdata[17:16] != want.status)
                    report_mismatch("status", m_tdata[17:16], want.status);
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic wait_drained();
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_region_size(input logic [16:0] bytes);
        @(negedge clk);
        s_tvalid    <= 1'b0;
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bytes;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        format_region(bytes);
        live_blocks.delete();
    endtask

    // one random item, mostly well-formed traffic
    task automatic random_item();
        int          pick, idx;
        logic [1:0]  cmd;
        logic [15:0] req, blk;
        logic [16:0] nrb;
        grant_t      got;
        pick = $urandom_range(0, 99);
        req = 16'($urandom);
        blk = 16'($urandom);
        nrb = 17'($urandom);
        if (pick < 45)
        begin
            cmd = CMD_ALLOC;
            case ($urandom_range(0, 9))
                0:       req = 16'($urandom_range(0, 65535));
                1, 2:    req = 16'($urandom_range(0, 600));
                default: req = 16'($urandom_range(0, 64));
            endcase
        end
        else if (pick < 85)
        begin
            cmd = CMD_FREE;
            if (live_blocks.size() != 0)
            begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                blk = 16'(live_blocks[idx]);
                live_blocks.delete(idx);
            end
        end
        else if (pick < 88)
            cmd = CMD_FREE;
        else
        begin
            cmd = ($urandom_range(0, 1) != 0) ? CMD_GROW : CMD_SHRINK;
            if ($urandom_range(0, 3) != 0)
                nrb = (cmd == CMD_GROW) ? 17'(shadow_end + $urandom_range(0, 256))
                                        : 17'(shadow_end - $urandom_range(0, 256));
        end
        send_item(cmd, req, blk, nrb, 1'b0, '0, got);
    endtask

    stim_row_t directed [$];

    function automatic stim_row_t row(input logic [1:0] cmd, input logic [15:0] req,
                                      input logic [15:0] blk, input logic [16:0] nrb,
                                      input bit typed, input logic [15:0] off,
                                      input logic [1:0] st);
        stim_row_t r;
        r.cmd = cmd;
        r.req = req;
        r.blk = blk;
        r.nrb = nrb;
        r.typed = typed;
        r.want.offset = off;
        r.want.status = st;
        return r;
    endfunction

    initial
    begin
        logic [16:0] region_sizes [6];
        grant_t      got;
        region_sizes = '{17'd65536, 17'd600, 17'd0, 17'd131071, 17'd2048, 17'd16};
        errors = 0;
        sent_items = 0;
        seen_results = 0;
        idle_pct = 0;
        stall_pct = 0;
        status_seen = '{0, 0, 0, 0};
        rst_n = 1'b0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        format_region(17'd65536);

        // directed: extremes, every command, the special cases
        directed.push_back(row(CMD_ALLOC,  16'd0,     16'd0,     17'd0,  1, 16'd12, ST_OK));
        directed.push_back(row(CMD_ALLOC,  16'hFFFF,  16'd0,     17'd0,  1, 16'd0,  ST_NO_FIT));
        directed.push_back(row(CMD_FREE,   16'd0,     16'd0,     17'd0,  1, 16'd0,  ST_NOT_PLACED));
        directed.push_back(row(CMD_FREE,   16'd0,     16'd8,     17'd0,  1, 16'd0,  ST_NOT_PLACED));
        directed.push_back(row(CMD_GROW,   16'd0,     16'd0, 17'h1FFFF,  1, 16'd0,  ST_OK));
        directed.push_back(row(CMD_ALLOC,  16'd100,   16'd0,     17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_ALLOC,  16'd200,   16'd0,     17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_ALLOC,  16'd50,    16'd0,     17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_FREE,   16'd0,     16'd20,    17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_FREE,   16'd0,     16'd328,   17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_FREE,   16'd0,     16'd124,   17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_FREE,   16'd0,     16'd124,   17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_FREE,   16'd0,     16'hFFFF,  17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_SHRINK, 16'd0,     16'd0,  17'd1000,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_SHRINK, 16'd0,     16'd0,     17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_ALLOC,  16'd1,     16'd0,     17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_GROW,   16'd0,     16'd0,  17'd2000,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_ALLOC,  16'd20,    16'd0,     17'd0,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_SHRINK, 16'd0,     16'd0,    17'd24,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_SHRINK, 16'd0,     16'd0,    17'd40,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_GROW,   16'd0,     16'd0,  17'd2000,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_GROW,   16'd0,     16'd0,  17'd2000,  0, 16'd0,  ST_OK));
        directed.push_back(row(CMD_SHRINK, 16'd0,     16'd0, 17'h1FFFF,  0, 16'd0,  ST_OK));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].cmd, directed[i].req, directed[i].blk, directed[i].nrb,
                      directed[i].typed, directed[i].want, got);

        // random phases, each after a new region size write, idling pattern chosen by phase mod 4
        for (int ph = 0; ph < 6; ph++)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            wait_drained();
            write_region_size(region_sizes[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            repeat (190)
                random_item();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge clk);

        $display("%0d items sent, %0d results checked over six region sizes",
                 sent_items, seen_results);
        $display("status counts ok/no-fit/not-placed/shrink-hit: %0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (errors == 0 && pending_grants.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
